// ----- rtl/core/circular_orbit_position_assert.svh -----
// Assertion macros for the circular orbit position block.
`ifndef CIRCULAR_ORBIT_POSITION_ASSERT_SVH
`define CIRCULAR_ORBIT_POSITION_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define COP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define COP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- rtl/core/cop_pkg.sv -----
// Package with constants, types and the arctangent table of the orbit block.
package cop_pkg;
  localparam int CordicSteps = 24;
  localparam int MaxSteps    = 32;
  localparam logic signed [33:0] CordicX0 = 34'sd652032874;

  localparam logic [2:0] REG_HAS_PARENT = 3'd0;
  localparam logic [2:0] REG_RADIUS     = 3'd1;
  localparam logic [2:0] REG_ORATE      = 3'd2;
  localparam logic [2:0] REG_PHASE      = 3'd3;
  localparam logic [2:0] REG_INCL       = 3'd4;
  localparam logic [2:0] REG_NODE       = 3'd5;
  localparam logic [2:0] REG_SRATE      = 3'd6;
  localparam logic [2:0] REG_RETRO      = 3'd7;

  // One CORDIC lane: x, y in Q2.30 with headroom, residual angle.
  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [32:0] z;
    logic [1:0]         quad;
  } lane_t;

  function automatic logic [31:0] atan_turns(input int i);
    logic [31:0] t;
    begin
      case (i)
        0: t = 32'h20000000; 1: t = 32'h12E4051E; 2: t = 32'h09FB385B;
        3: t = 32'h051111D4; 4: t = 32'h028B0D43; 5: t = 32'h0145D7E1;
        6: t = 32'h00A2F61E; 7: t = 32'h00517C55; 8: t = 32'h0028BE53;
        9: t = 32'h00145F2F; 10: t = 32'h000A2F98; 11: t = 32'h000517CC;
        12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2FA;
        15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
        18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
        21: t = 32'h00000146; 22: t = 32'h000000A3; 23: t = 32'h00000051;
        24: t = 32'h00000029; 25: t = 32'h00000014; 26: t = 32'h0000000A;
        27: t = 32'h00000005; 28: t = 32'h00000003; 29: t = 32'h00000001;
        30: t = 32'h00000001;
        default: t = 32'h00000000;
      endcase
      return t;
    end
  endfunction

  // Seeds a lane from a binary-turn angle.
  function automatic lane_t lane_init(input logic [31:0] ang);
    lane_t l;
    logic [31:0] b;
    begin
      b = ang + 32'h20000000;
      l.quad = b[31:30];
      l.z = $signed({3'b000, b[29:0]}) - 33'sh20000000;
      l.x = CordicX0;
      l.y = '0;
      return l;
    end
  endfunction

  // One micro-rotation of step i.
  function automatic lane_t lane_step(input lane_t l, input int i);
    lane_t o;
    logic signed [33:0] dx, dy;
    logic signed [32:0] a;
    begin
      o = l;
      dx = l.y >>> i;
      dy = l.x >>> i;
      a = $signed({1'b0, atan_turns(i)});
      if (!l.z[32]) begin
        o.x = l.x - dx; o.y = l.y + dy; o.z = l.z - a;
      end else begin
        o.x = l.x + dx; o.y = l.y - dy; o.z = l.z + a;
      end
      return o;
    end
  endfunction

  // Product rounding: floor((p + 2^29) / 2^30) kept to 64 bits.
  function automatic logic signed [63:0] round30(input logic signed [65:0] p);
    logic signed [65:0] q;
    begin
      q = (p + 66'sd536870912) >>> 30;
      return q[63:0];
    end
  endfunction
endpackage

// ----- rtl/core/circular_orbit_position.sv -----
// Pipelined circular orbit position unit: CORDIC sin/cos and two rotations.
// One beat is accepted every clock cycle while the result side keeps moving.
// A result is offered once its beat has passed through one angle-product
// stage, (CORDIC_STEPS+1)/2 CORDIC stages, seven fold, multiply and rounding
// stages, and the output register. Three CORDIC lanes (orbit, inclination
// and node angle) share one pipeline running two micro-rotations per stage,
// then registered multiply stages form r*cos/sin, the tilt about x and the
// node turn about y, each product registered before
// use. A result that waits at the output freezes every stage together, and the
// input with it, so nothing is lost or repeated; full rate resumes as soon as
// the waiting result is taken.
module circular_orbit_position #(
  parameter int CORDIC_STEPS = cop_pkg::CordicSteps
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        in_sim_time,
  input  logic signed [31:0] in_parent_x,
  input  logic signed [31:0] in_parent_y,
  input  logic signed [31:0] in_parent_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic [31:0]        out_orbit_angle,
  output logic [31:0]        out_spin_angle
);
  `include "circular_orbit_position_assert.svh"

  localparam int NC = (CORDIC_STEPS + 1) / 2;  // CORDIC stages, two steps each
  localparam int NS = NC + 8;                  // pipeline stages before the output register

  // Configuration registers.
  logic        has_parent_r, retro_r;
  logic [30:0] radius_r;
  logic [31:0] orate_r, phase_r, incl_r, node_r, srate_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      has_parent_r <= 1'b0; retro_r <= 1'b0; radius_r <= '0;
      orate_r <= '0; phase_r <= '0; incl_r <= '0; node_r <= '0; srate_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        cop_pkg::REG_HAS_PARENT: has_parent_r <= cfg_data[0];
        cop_pkg::REG_RADIUS:     radius_r <= cfg_data[30:0];
        cop_pkg::REG_ORATE:      orate_r <= cfg_data;
        cop_pkg::REG_PHASE:      phase_r <= cfg_data;
        cop_pkg::REG_INCL:       incl_r <= cfg_data;
        cop_pkg::REG_NODE:       node_r <= cfg_data;
        cop_pkg::REG_SRATE:      srate_r <= cfg_data;
        cop_pkg::REG_RETRO:      retro_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The whole pipeline advances when the output register is free or drains.
  logic adv;
  logic [NS-1:0] vld_r;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NS-2:0], in_valid};
    end
  end

  // Stage 0: angle products (one 32x32 multiply each).
  logic [31:0] oang_r, spin_r;
  logic signed [31:0] p0x_r, p0y_r, p0z_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      oang_r <= phase_r - 32'(orate_r * in_sim_time);
      spin_r <= retro_r ? 32'(0) - 32'(srate_r * in_sim_time)
                        : 32'(srate_r * in_sim_time);
      p0x_r <= in_parent_x; p0y_r <= in_parent_y; p0z_r <= in_parent_z;
    end
  end

  // CORDIC stages; payload that rides alongside is carried in shift lines.
  cop_pkg::lane_t lo_r [1:NC], li_r [1:NC], ln_r [1:NC];
  logic [31:0] oang_d [1:NC];
  logic [31:0] spin_d [1:NC];
  logic signed [31:0] px_d [1:NC], py_d [1:NC], pz_d [1:NC];

  for (genvar g = 0; g < NC; g++) begin : g_cordic
    cop_pkg::lane_t lo_in, li_in, ln_in;
    cop_pkg::lane_t o1, i1, n1, o2, i2, n2;
    logic [31:0] oang_in, spin_in;
    logic signed [31:0] px_in, py_in, pz_in;
    if (g == 0) begin : g_first
      // The first stage seeds its lanes straight from the angle registers.
      assign lo_in = cop_pkg::lane_init(oang_r);
      assign li_in = cop_pkg::lane_init(incl_r);
      assign ln_in = cop_pkg::lane_init(node_r);
      assign oang_in = oang_r;
      assign spin_in = spin_r;
      assign px_in = p0x_r;
      assign py_in = p0y_r;
      assign pz_in = p0z_r;
    end else begin : g_next
      assign lo_in = lo_r[g];
      assign li_in = li_r[g];
      assign ln_in = ln_r[g];
      assign oang_in = oang_d[g];
      assign spin_in = spin_d[g];
      assign px_in = px_d[g];
      assign py_in = py_d[g];
      assign pz_in = pz_d[g];
    end
    always_comb begin
      o1 = lo_in; i1 = li_in; n1 = ln_in;
      if (2*g < CORDIC_STEPS) begin
        o1 = cop_pkg::lane_step(lo_in, 2*g);
        i1 = cop_pkg::lane_step(li_in, 2*g);
        n1 = cop_pkg::lane_step(ln_in, 2*g);
      end
      o2 = o1; i2 = i1; n2 = n1;
      if (2*g+1 < CORDIC_STEPS) begin
        o2 = cop_pkg::lane_step(o1, 2*g+1);
        i2 = cop_pkg::lane_step(i1, 2*g+1);
        n2 = cop_pkg::lane_step(n1, 2*g+1);
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        lo_r[g+1] <= o2; li_r[g+1] <= i2; ln_r[g+1] <= n2;
        oang_d[g+1] <= oang_in; spin_d[g+1] <= spin_in;
        px_d[g+1] <= px_in; py_d[g+1] <= py_in; pz_d[g+1] <= pz_in;
      end
    end
  end

  // Quadrant fold: each lane gives cos and sin in Q2.30.
  function automatic logic signed [33:0] fold_c(input cop_pkg::lane_t l);
    case (l.quad)
      2'd0: return l.x;
      2'd1: return -l.y;
      2'd2: return -l.x;
      default: return l.y;
    endcase
  endfunction
  function automatic logic signed [33:0] fold_s(input cop_pkg::lane_t l);
    case (l.quad)
      2'd0: return l.y;
      2'd1: return l.x;
      2'd2: return -l.y;
      default: return -l.x;
    endcase
  endfunction

  // Stage A: fold to sin/cos.
  logic signed [33:0] co_r, so_r, ci_r, si_r, cn_r, sn_r;
  // Stage B: radius products. Stage C: round to px, pz.
  logic signed [65:0] rco_r, rso_r;
  logic signed [63:0] pxa_r, pza_r;
  // Stage D: tilt products. Stage E: round to y1, z1.
  logic signed [65:0] m_y_r, m_z_r;
  logic signed [63:0] pxb_r, pxc_r, y1_r, z1_r;
  // Stage F: node products. Stage G: sums and round.
  logic signed [65:0] m_xc_r, m_zs_r, m_xs_r, m_zc_r;
  logic signed [63:0] y1b_r, x2_r, z2_r, y1c_r;
  logic [31:0] ang_a_r, ang_b_r, ang_c_r, ang_d_r, ang_e_r, ang_f_r, ang_g_r;
  logic [31:0] sp_a_r, sp_b_r, sp_c_r, sp_d_r, sp_e_r, sp_f_r, sp_g_r;
  logic signed [31:0] qx_r [7], qy_r [7], qz_r [7];
  logic signed [33:0] sia_r, cia_r, cna_r, sna_r, cnb_r, snb_r, cnc_r, snc_r;
  logic signed [33:0] cnd_r, snd_r;

  // The rounded px, pz, y1 and z1 all fit in 33 signed bits, so only those
  // bits of px, pz and z1 enter the multipliers.
  always_ff @(posedge clk) begin
    if (adv) begin
      co_r <= fold_c(lo_r[NC]); so_r <= fold_s(lo_r[NC]);
      ci_r <= fold_c(li_r[NC]); si_r <= fold_s(li_r[NC]);
      cn_r <= fold_c(ln_r[NC]); sn_r <= fold_s(ln_r[NC]);
      ang_a_r <= oang_d[NC]; sp_a_r <= spin_d[NC];
      qx_r[0] <= px_d[NC]; qy_r[0] <= py_d[NC]; qz_r[0] <= pz_d[NC];
      for (int k = 1; k < 7; k++) begin
        qx_r[k] <= qx_r[k-1]; qy_r[k] <= qy_r[k-1]; qz_r[k] <= qz_r[k-1];
      end
      // B
      rco_r <= 66'($signed({1'b0, radius_r}) * co_r);
      rso_r <= 66'($signed({1'b0, radius_r}) * so_r);
      sia_r <= si_r; cia_r <= ci_r; cna_r <= cn_r; sna_r <= sn_r;
      ang_b_r <= ang_a_r; sp_b_r <= sp_a_r;
      // C
      pxa_r <= cop_pkg::round30(rco_r); pza_r <= cop_pkg::round30(rso_r);
      cnb_r <= cna_r; snb_r <= sna_r;
      ang_c_r <= ang_b_r; sp_c_r <= sp_b_r;
      // D
      m_y_r <= 66'(-($signed(pza_r[32:0]) * sia_r));
      m_z_r <= 66'($signed(pza_r[32:0]) * cia_r);
      pxb_r <= pxa_r; cnc_r <= cnb_r; snc_r <= snb_r;
      ang_d_r <= ang_c_r; sp_d_r <= sp_c_r;
      // E
      y1_r <= cop_pkg::round30(m_y_r); z1_r <= cop_pkg::round30(m_z_r);
      pxc_r <= pxb_r; cnd_r <= cnc_r; snd_r <= snc_r;
      ang_e_r <= ang_d_r; sp_e_r <= sp_d_r;
      // F
      m_xc_r <= 66'($signed(pxc_r[32:0]) * cnd_r);
      m_zs_r <= 66'($signed(z1_r[32:0]) * snd_r);
      m_xs_r <= 66'($signed(pxc_r[32:0]) * snd_r);
      m_zc_r <= 66'($signed(z1_r[32:0]) * cnd_r);
      y1b_r <= y1_r;
      ang_f_r <= ang_e_r; sp_f_r <= sp_e_r;
      // G
      x2_r <= cop_pkg::round30(m_xc_r + m_zs_r);
      z2_r <= cop_pkg::round30(m_zc_r - m_xs_r);
      y1c_r <= y1b_r;
      ang_g_r <= ang_f_r; sp_g_r <= sp_f_r;
    end
  end

  // Note: px is carried through stage E as pxc_r so that it meets z1_r in stage F.
  // Output register: add parent position, else zero position and orbit angle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vld_r[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_spin_angle <= sp_g_r;
      if (has_parent_r) begin
        out_pos_x <= x2_r[31:0] + qx_r[6];
        out_pos_y <= y1c_r[31:0] + qy_r[6];
        out_pos_z <= z2_r[31:0] + qz_r[6];
        out_orbit_angle <= ang_g_r;
      end else begin
        out_pos_x <= '0; out_pos_y <= '0; out_pos_z <= '0;
        out_orbit_angle <= '0;
      end
    end
  end

  `COP_ASSERT_NXT(a_stall_holds, out_valid && !out_ready, out_valid)
  `COP_ASSERT_IMP(a_ready_follows_output, !out_valid, in_ready)
  `COP_ASSERT_NXT(a_no_parent_zero, out_valid && !has_parent_r && adv && vld_r[NS-1],
    out_pos_x == 32'sd0 && out_orbit_angle == 32'd0)
endmodule

// ----- verif/tb.sv -----
// Testbench for the circular orbit position block: directed table, then random beats.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // The pipeline is CORDIC_STEPS/2 + 8 stages plus the output register; we allow
  // a comfortable margin for results still in flight before touching registers.
  localparam int Latency = cop_pkg::CordicSteps / 2 + 12;
  localparam int Limit   = 400000;

  typedef struct {
    logic [31:0]        tm;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
  } beat_in_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [31:0]        oang;
    logic [31:0]        spin;
  } beat_out_t;

  // Directed row: a beat, and optionally a result that can be read off directly.
  typedef struct {
    beat_in_t  b;
    bit        typed;
    beat_out_t r;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [31:0] in_sim_time = '0;
  logic signed [31:0] in_parent_x = '0, in_parent_y = '0, in_parent_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;
  logic [31:0] out_orbit_angle, out_spin_angle;

  always #6 clk = ~clk;

  circular_orbit_position dut (.*);

  // Our own copy of the register file, starting from the reset values.
  bit          m_parent = 1'b0, m_retro = 1'b0;
  logic [30:0] m_radius = '0;
  logic [31:0] m_orate = '0, m_phase = '0, m_incl = '0, m_node = '0, m_srate = '0;

  beat_out_t pending_pos[$];
  bit  failed = 1'b0;
  int  cycles = 0;
  int  send_idle = 0, recv_stall = 0;
  int  hold_off = 0;

  localparam logic [31:0] AtanTab[32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000};

  // Cosine and sine of a binary-turn angle, Q2.30, by the same rotation sequence.
  function automatic void turn_sincos(input logic [31:0] ang, output longint c,
                                      output longint s);
    logic [31:0] b;
    longint x, y, z, dx, dy;
    b = ang + 32'h20000000;
    z = longint'(b[29:0]) - 64'sh20000000;
    x = 652032874;
    y = 0;
    for (int i = 0; i < cop_pkg::CordicSteps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(AtanTab[i]);
      end else begin
        x += dx; y -= dy; z += longint'(AtanTab[i]);
      end
    end
    case (b[31:30])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  // Rounded Q2.30 product; 128 bits keep the sums exact.
  function automatic longint rnd30(input logic signed [127:0] p);
    logic signed [127:0] q;
    q = (p + 128'sd536870912) >>> 30;
    return longint'(q[63:0]);
  endfunction

  function automatic beat_out_t orbit_position(input beat_in_t b);
    beat_out_t r;
    longint co, so, ci, si, cn, sn, px, pz, y1, z1, x2, z2;
    logic [31:0] spin;
    spin = m_srate * b.tm;
    r.spin = m_retro ? 32'd0 - spin : spin;
    r.x = '0; r.y = '0; r.z = '0; r.oang = '0;
    if (m_parent) begin
      r.oang = m_phase - m_orate * b.tm;
      turn_sincos(r.oang, co, so);
      turn_sincos(m_incl, ci, si);
      turn_sincos(m_node, cn, sn);
      px = rnd30(128'(longint'(m_radius)) * co);
      pz = rnd30(128'(longint'(m_radius)) * so);
      y1 = rnd30(-(128'(pz) * si));
      z1 = rnd30(128'(pz) * ci);
      x2 = rnd30(128'(px) * cn + 128'(z1) * sn);
      z2 = rnd30(-(128'(px) * sn) + 128'(z1) * cn);
      r.x = 32'(x2) + b.px;
      r.y = 32'(y1) + b.py;
      r.z = 32'(z2) + b.pz;
    end
    return r;
  endfunction

  // Registers are only written while the pipeline is empty.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      cop_pkg::REG_HAS_PARENT: m_parent = val[0];
      cop_pkg::REG_RADIUS:     m_radius = val[30:0];
      cop_pkg::REG_ORATE:      m_orate = val;
      cop_pkg::REG_PHASE:      m_phase = val;
      cop_pkg::REG_INCL:       m_incl = val;
      cop_pkg::REG_NODE:       m_node = val;
      cop_pkg::REG_SRATE:      m_srate = val;
      cop_pkg::REG_RETRO:      m_retro = val[0];
      default: ;
    endcase
  endtask

  // Withdraws the offer and waits until every expected result has come.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_pos.size() != 0) @(posedge clk);
    repeat (Latency) @(posedge clk);
  endtask

  // Offers one beat, idling beforehand in step with the current idling phase.
  task automatic offer(input beat_in_t b);
    while (send_idle != 0 && $urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sim_time <= b.tm; in_parent_x <= b.px; in_parent_y <= b.py; in_parent_z <= b.pz;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_pos.push_back(orbit_position(b));
  endtask

  function automatic beat_in_t rand_beat();
    beat_in_t b;
    b.tm = $urandom();
    if ($urandom_range(3) == 0) b.tm = $urandom_range(255);
    b.px = $urandom(); b.py = $urandom(); b.pz = $urandom();
    return b;
  endfunction

  task automatic rand_config;
    logic [31:0] ext[4];
    ext = '{32'h0, 32'hFFFFFFFF, 32'h40000000, 32'h80000000};
    write_reg(cop_pkg::REG_HAS_PARENT, {31'd0, $urandom_range(7) != 0});
    // Radius: one time in four an edge value, otherwise a random 32-bit word.
    write_reg(cop_pkg::REG_RADIUS,
              $urandom_range(3) == 0 ? ext[$urandom_range(3)] : $urandom());
    write_reg(cop_pkg::REG_ORATE,
              $urandom_range(4) == 0 ? ext[$urandom_range(3)] : $urandom());
    write_reg(cop_pkg::REG_PHASE, $urandom());
    write_reg(cop_pkg::REG_INCL,
              $urandom_range(4) == 0 ? ext[$urandom_range(3)] : $urandom());
    write_reg(cop_pkg::REG_NODE,
              $urandom_range(4) == 0 ? ext[$urandom_range(3)] : $urandom());
    write_reg(cop_pkg::REG_SRATE, $urandom());
    write_reg(cop_pkg::REG_RETRO, $urandom());
  endtask

  // Receiver: random stalls, plus one long hold-off counted here.
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(recv_stall != 0 && $urandom_range(99) < recv_stall);
    end
  end

  // Every accepted result beat is compared with the oldest expectation.
  always @(posedge clk) begin
    beat_out_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_pos.size() == 0) begin
        $display("%0t: result beat with nothing expected", $time);
        failed = 1'b1;
      end else begin
        e = pending_pos.pop_front();
        if (out_pos_x !== e.x || out_pos_y !== e.y || out_pos_z !== e.z ||
            out_orbit_angle !== e.oang || out_spin_angle !== e.spin) begin
          $display("%0t: mismatch expected x=%h y=%h z=%h orb=%h spin=%h", $time,
                   e.x, e.y, e.z, e.oang, e.spin);
          $display("%0t:          actual   x=%h y=%h z=%h orb=%h spin=%h", $time,
                   out_pos_x, out_pos_y, out_pos_z, out_orbit_angle, out_spin_angle);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > Limit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    row_t rw;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // After reset: no parent, zero rates, so every field reads zero.
    rw.typed = 1'b1;
    rw.r = '{x: 0, y: 0, z: 0, oang: 0, spin: 0};
    rw.b = '{tm: 32'hFFFFFFFF, px: 32'sh7FFFFFFF, py: 32'sh80000000, pz: -1};
    rows.push_back(rw);
    rw.b = '{tm: 0, px: 0, py: 0, pz: 0};
    rows.push_back(rw);
    foreach (rows[i]) begin
      offer(rows[i].b);
      if (rows[i].typed) pending_pos[$] = rows[i].r;
    end
    drain();

    // Retrograde spin with no parent: parent inputs must be ignored.
    m_parent = 0;
    write_reg(cop_pkg::REG_SRATE, 32'h00000001);
    write_reg(cop_pkg::REG_RETRO, 32'h00000003);
    rw.b = '{tm: 32'd5, px: 32'sh12345678, py: 1, pz: 2};
    rw.r = '{x: 0, y: 0, z: 0, oang: 0, spin: 32'hFFFFFFFB};
    offer(rw.b); pending_pos[$] = rw.r;
    drain();

    // Parent on, zero radius: the body sits on the parent.
    write_reg(cop_pkg::REG_HAS_PARENT, 32'hFFFFFFFF);
    write_reg(cop_pkg::REG_PHASE, 32'h12345678);
    rw.b = '{tm: 0, px: 32'sh7FFFFFFF, py: 32'sh80000000, pz: 32'sh00010000};
    rw.r = '{x: 32'sh7FFFFFFF, y: 32'sh80000000, z: 32'sh00010000, oang: 32'h12345678,
             spin: 0};
    offer(rw.b); pending_pos[$] = rw.r;
    drain();

    // Extremes of radius and angles; checked against the predictor.
    write_reg(cop_pkg::REG_RADIUS, 32'hFFFFFFFF);
    write_reg(cop_pkg::REG_ORATE, 32'hFFFFFFFF);
    write_reg(cop_pkg::REG_SRATE, 32'hFFFFFFFF);
    write_reg(cop_pkg::REG_RETRO, 0);
    for (int q = 0; q < 16; q++) begin
      write_reg(cop_pkg::REG_INCL, q * 32'h20000000);
      write_reg(cop_pkg::REG_NODE, 32'h80000000 - q * 32'h10000000);
      rw.b = '{tm: q * 32'h1FFFFFFF, px: (q & 1) ? 32'sh7FFFFFFF : 32'sh80000000,
               py: -q, pz: q << 27};
      offer(rw.b);
      drain();
    end

    // Random part: eight phases cycling through four idling settings, registers changed between them.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 81; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 81; end
        default: begin send_idle = 27; recv_stall = 27; end
      endcase
      rand_config();
      if (ph == 0) hold_off = 200;
      for (int n = 0; n < 128; n++) begin
        offer(rand_beat());
        // Sender pause until all results are back.
        if (n == 60) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending_pos.size() != 0) @(posedge clk);
        end
      end
      drain();
    end

    send_idle = 0; recv_stall = 0;
    drain();
    if (!failed) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/cop_pkg.sv
rtl/core/circular_orbit_position.sv
verif/tb.sv
